// File: hdl/slx_pkg.sv
// Shared types, codes and helper functions of the script lexer token scanner.
`default_nettype none

package slx_pkg;

    // Width of the internal offset counters; reported offsets are 16 bits.
    localparam int POS_BITS  = 16;
    localparam int OUT_POS_W = 16;
    localparam int TYPE_W    = 4;
    localparam int MAX_TOK   = 3;
    localparam int TOKCNT_W  = 2;

    // Depth of the group queue between the scanner and the token sender.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [POS_BITS-1:0] t_pos;

    // Token type codes.
    localparam logic [TYPE_W-1:0] T_OTHER   = 4'd0;
    localparam logic [TYPE_W-1:0] T_END     = 4'd1;
    localparam logic [TYPE_W-1:0] T_LINE    = 4'd2;
    localparam logic [TYPE_W-1:0] T_PREPROC = 4'd3;
    localparam logic [TYPE_W-1:0] T_BLOCK   = 4'd4;
    localparam logic [TYPE_W-1:0] T_STRING  = 4'd5;
    localparam logic [TYPE_W-1:0] T_ESCAPE  = 4'd6;
    localparam logic [TYPE_W-1:0] T_RAW     = 4'd7;
    localparam logic [TYPE_W-1:0] T_NEWLINE = 4'd8;
    localparam logic [TYPE_W-1:0] T_OPER    = 4'd9;
    localparam logic [TYPE_W-1:0] T_IDENT   = 4'd10;
    localparam logic [TYPE_W-1:0] T_NUMBER  = 4'd11;

    // Scanner mode codes.
    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_SLASH   = 4'd1;
    localparam logic [3:0] M_SLASH2  = 4'd2;
    localparam logic [3:0] M_LINE    = 4'd3;
    localparam logic [3:0] M_PREPROC = 4'd4;
    localparam logic [3:0] M_BLOCK   = 4'd5;
    localparam logic [3:0] M_STRING  = 4'd6;
    localparam logic [3:0] M_RAW     = 4'd7;
    localparam logic [3:0] M_CR      = 4'd8;
    localparam logic [3:0] M_IDENT   = 4'd9;
    localparam logic [3:0] M_NUMBER  = 4'd10;

    // Bit positions of the pending flags.
    localparam int FB_STAR = 0;
    localparam int FB_BSL  = 1;
    localparam int FB_PIPE = 2;

    // Character codes.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_C   = 8'h63;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_PIPE   = 8'h7C;

    typedef struct packed {
        logic [TYPE_W-1:0]    tok_type;
        logic [OUT_POS_W-1:0] start;
        logic [OUT_POS_W-1:0] stop;
    } t_token;

    // All tokens caused by one byte, in emission order.
    typedef struct packed {
        logic [TOKCNT_W-1:0]       count;
        t_token [MAX_TOK-1:0]      tok;
    } t_group;

    // Increment that sticks at the top value.
    function automatic t_pos sat_inc(input t_pos x);
        return (&x) ? x : x + t_pos'(1);
    endfunction

    // Reported offsets are the low 16 bits of the counter.
    function automatic logic [OUT_POS_W-1:0] pos_out(input t_pos x);
        logic [31:0] w;
        w = 32'(x);
        return w[OUT_POS_W-1:0];
    endfunction

    function automatic t_token mk_tok(input logic [TYPE_W-1:0] ty,
                                      input t_pos st, input t_pos sp);
        t_token t;
        t.tok_type = ty;
        t.start    = pos_out(st);
        t.stop     = pos_out(sp);
        return t;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF;
    endfunction

endpackage

`default_nettype wire

// File: hdl/slx_byte_if.sv
// Stream interface that carries text bytes into the scanner.
`default_nettype none

interface slx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/slx_token_if.sv
// Stream interface that carries tokens out of the scanner.
`default_nettype none

interface slx_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  tok_kind;
    logic [15:0] start_pos;
    logic [15:0] stop_pos;
    logic        last_of_run;

    modport source (output valid, output tok_kind, output start_pos,
                    output stop_pos, output last_of_run, input ready);
    modport sink (input valid, input tok_kind, input start_pos,
                  input stop_pos, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: hdl/script_lexer_token_scanner.sv
// Top level of the script lexer token scanner: front end, group queue, back end.
// Throughput: one byte per cycle while the queue is not full; the back sends the tokens of a group in turn,
// and the four-group queue lets the front keep taking bytes while the back drains tokens.
// Reset: synchronous, active low; clears the scanner mode, offsets, flags and queue pointers.
// No clearing pass is needed, so the block takes bytes in the first cycle after reset.
`default_nettype none

module script_lexer_token_scanner
    import slx_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    slx_byte_if.sink    i_byte,
    slx_token_if.source o_token
);

    logic   push, full, pop, head_valid;
    t_group group, head;

    slx_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_full  (full),
        .o_push  (push),
        .o_group (group)
    );

    slx_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_group      (group),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    slx_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_token      (o_token)
    );

endmodule

`default_nettype wire

// File: hdl/slx_front.sv
// Front end: accepts text bytes, runs the scanner state and forms token groups.
`default_nettype none

module slx_front
    import slx_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    slx_byte_if.sink  i_byte,
    input  wire logic i_full,
    output logic      o_push,
    output t_group    o_group
);

    logic [3:0] r_mode, n_mode;
    t_pos       r_tb, n_tb;
    t_pos       r_pos, n_pos;
    logic [2:0] r_flags, n_flags;

    logic   acc;
    logic   [7:0] c;
    logic   [3:0] cv;
    t_token [3:0] cand;
    t_group grp;

    assign c            = i_byte.ch;
    assign i_byte.ready = !i_full;
    assign acc          = i_byte.valid && !i_full;

    // Scan one byte: the open token first, then a fresh look from idle if needed.
    always_comb begin
        logic       again;
        logic       esc_hit;
        logic [3:0] m;
        t_pos       tb;
        t_pos       p;
        t_pos       pn;
        t_pos       esc_st;
        logic [2:0] fl;
        logic [TYPE_W-1:0] fin_ty;
        logic       fin_open;
        logic [TOKCNT_W-1:0] n;

        p       = r_pos;
        m       = r_mode;
        tb      = r_tb;
        fl      = r_flags;
        again   = 1'b0;
        esc_hit = 1'b0;
        cv      = '0;
        cand    = '0;
        fin_ty  = T_OTHER;
        fin_open = 1'b0;
        n       = '0;
        grp     = '0;
        esc_st  = (p == '0) ? '0 : ((&p) ? p : p - t_pos'(1));

        case (r_mode)
            M_SLASH: begin
                if (c == CH_SLASH) begin
                    m = M_SLASH2;
                end else if (c == CH_STAR) begin
                    m  = M_BLOCK;
                    fl = '0;
                end else begin
                    cv[0]   = 1'b1;
                    cand[0] = mk_tok(T_OTHER, tb, sat_inc(tb));
                    m       = M_IDLE;
                    again   = 1'b1;
                end
            end
            M_SLASH2, M_LINE, M_PREPROC: begin
                if (c == CH_CR || c == CH_LF) begin
                    cv[0]   = 1'b1;
                    cand[0] = mk_tok((r_mode == M_PREPROC) ? T_PREPROC : T_LINE, tb, p);
                    m       = M_IDLE;
                    again   = 1'b1;
                end else if (r_mode == M_SLASH2) begin
                    m = (c == CH_BANG) ? M_PREPROC : M_LINE;
                end
            end
            M_BLOCK: begin
                if (fl[FB_STAR] && c == CH_SLASH) begin
                    cv[0]   = 1'b1;
                    cand[0] = mk_tok(T_BLOCK, tb, sat_inc(p));
                    m       = M_IDLE;
                    fl      = '0;
                end else begin
                    fl = '0;
                    fl[FB_STAR] = (c == CH_STAR);
                end
            end
            M_STRING: begin
                if (fl[FB_BSL]) begin
                    esc_hit = c == CH_BSL || c == CH_LC_N || c == CH_LC_T || c == CH_DQUOTE;
                end else if (fl[FB_PIPE]) begin
                    esc_hit = c == CH_LC_C || c == CH_LC_N || c == CH_LC_R;
                end
                if (fl[FB_BSL] || fl[FB_PIPE]) begin
                    fl = '0;
                end
                if (esc_hit) begin
                    cv[0]   = 1'b1;
                    cand[0] = mk_tok(T_ESCAPE, esc_st, sat_inc(p));
                end else if (c == CH_DQUOTE) begin
                    cv[0]   = 1'b1;
                    cand[0] = mk_tok(T_STRING, tb, sat_inc(p));
                    m       = M_IDLE;
                end else if (c == CH_BSL) begin
                    fl = '0;
                    fl[FB_BSL] = 1'b1;
                end else if (c == CH_PIPE) begin
                    fl = '0;
                    fl[FB_PIPE] = 1'b1;
                end
            end
            M_RAW: begin
                if (c == CH_SQUOTE) begin
                    cv[0]   = 1'b1;
                    cand[0] = mk_tok(T_RAW, tb, sat_inc(p));
                    m       = M_IDLE;
                end
            end
            M_CR: begin
                cv[0] = 1'b1;
                m     = M_IDLE;
                if (c == CH_LF) begin
                    cand[0] = mk_tok(T_NEWLINE, tb, sat_inc(p));
                end else begin
                    cand[0] = mk_tok(T_NEWLINE, tb, sat_inc(tb));
                    again   = 1'b1;
                end
            end
            M_IDENT: begin
                if (!(is_letter(c) || is_digit(c) || c == CH_UNDER)) begin
                    cv[0]   = 1'b1;
                    cand[0] = mk_tok(T_IDENT, tb, p);
                    m       = M_IDLE;
                    again   = 1'b1;
                end
            end
            M_NUMBER: begin
                if (!is_digit(c)) begin
                    cv[0]   = 1'b1;
                    cand[0] = mk_tok(T_NUMBER, tb, p);
                    m       = M_IDLE;
                    again   = 1'b1;
                end
            end
            default: begin
                m     = M_IDLE;
                again = 1'b1;
            end
        endcase

        // Classify the byte as the first byte of a new token.
        if (again) begin
            tb = p;
            fl = '0;
            if (!is_blank(c)) begin
                case (c)
                    CH_SLASH:  m = M_SLASH;
                    CH_DQUOTE: m = M_STRING;
                    CH_SQUOTE: m = M_RAW;
                    CH_CR:     m = M_CR;
                    CH_LF: begin
                        cv[1]   = 1'b1;
                        cand[1] = mk_tok(T_NEWLINE, p, sat_inc(p));
                    end
                    CH_COMMA, CH_DOT, CH_LBRACK, CH_RBRACK, CH_LPAREN, CH_RPAREN: begin
                        cv[1]   = 1'b1;
                        cand[1] = mk_tok(T_OPER, p, sat_inc(p));
                    end
                    default: begin
                        if (is_letter(c) || c == CH_UNDER) begin
                            m = M_IDENT;
                        end else if (is_digit(c)) begin
                            m = M_NUMBER;
                        end else begin
                            cv[1]   = 1'b1;
                            cand[1] = mk_tok(T_OTHER, p, sat_inc(p));
                        end
                    end
                endcase
            end
        end

        pn = sat_inc(p);

        // End of text: close the open token, add the end token and start over.
        if (i_byte.last) begin
            fin_open = 1'b1;
            case (m)
                M_SLASH:             fin_ty = T_OTHER;
                M_SLASH2, M_LINE:    fin_ty = T_LINE;
                M_PREPROC:           fin_ty = T_PREPROC;
                M_BLOCK:             fin_ty = T_BLOCK;
                M_STRING:            fin_ty = T_STRING;
                M_RAW:               fin_ty = T_RAW;
                M_CR:                fin_ty = T_NEWLINE;
                M_IDENT:             fin_ty = T_IDENT;
                M_NUMBER:            fin_ty = T_NUMBER;
                default:             fin_open = 1'b0;
            endcase
            cv[2]   = fin_open;
            cand[2] = mk_tok(fin_ty, tb, (m == M_SLASH) ? sat_inc(tb) : pn);
            cv[3]   = 1'b1;
            cand[3] = mk_tok(T_END, pn, pn);
            n_mode  = M_IDLE;
            n_tb    = '0;
            n_pos   = '0;
            n_flags = '0;
        end else begin
            n_mode  = m;
            n_tb    = tb;
            n_pos   = pn;
            n_flags = fl;
        end

        // Pack the valid candidates in order.
        for (int k = 0; k < 4; k++) begin
            if (cv[k] && n != TOKCNT_W'(MAX_TOK)) begin
                grp.tok[n] = cand[k];
                n = n + TOKCNT_W'(1);
            end
        end
        grp.count = n;
    end

    assign o_push  = acc && (grp.count != '0);
    assign o_group = grp;

    // Scanner state advances on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_tb    <= '0;
            r_pos   <= '0;
            r_flags <= '0;
        end else if (acc) begin
            r_mode  <= n_mode;
            r_tb    <= n_tb;
            r_pos   <= n_pos;
            r_flags <= n_flags;
        end
    end

    // The end of a text always leaves the scanner in its reset state.
    a_fin_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_byte.last) |=> (r_pos == '0 && r_mode == M_IDLE && r_flags == '0))
        else $error("scanner state not cleared after end of text");

    // A final byte always produces at least the end token.
    a_fin_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_byte.last) |-> o_push)
        else $error("end of text without a token group");

endmodule

`default_nettype wire

// File: hdl/slx_queue.sv
// Short queue of token groups between the scanner and the token sender.
`default_nettype none

module slx_queue
    import slx_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_group i_group,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_head_valid,
    output t_group      o_head
);

    t_group              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_count;
    logic                push, pop;

    assign o_full       = (r_count == QCNT_W'(QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];
    assign push         = i_push && !o_full;
    assign pop          = i_pop && o_head_valid;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] x);
        return (x == QPTR_W'(QDEPTH - 1)) ? '0 : x + QPTR_W'(1);
    endfunction

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Group storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_group;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue fill count out of range");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + QCNT_W'(1)))
        else $error("queue count did not follow a push");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_head_valid |-> (o_head.count != '0))
        else $error("empty token group in queue");

endmodule

`default_nettype wire

// File: hdl/slx_back.sv
// Back end: sends the tokens of each queued group one item per cycle while the token receiver is ready.
`default_nettype none

module slx_back
    import slx_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_head_valid,
    input  wire t_group i_head,
    output logic        o_pop,
    slx_token_if.source o_token
);

    logic [TOKCNT_W-1:0] r_idx;
    logic                is_last;
    logic                out_acc;
    t_token              tok;

    assign tok     = i_head.tok[r_idx];
    assign is_last = (r_idx == i_head.count - TOKCNT_W'(1));
    assign out_acc = i_head_valid && o_token.ready;
    assign o_pop   = out_acc && is_last;

    assign o_token.valid       = i_head_valid;
    assign o_token.tok_kind    = tok.tok_type;
    assign o_token.start_pos   = tok.start;
    assign o_token.stop_pos    = tok.stop;
    assign o_token.last_of_run = is_last;

    // Walk through the tokens of the head group.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (out_acc) begin
            r_idx <= is_last ? '0 : r_idx + TOKCNT_W'(1);
        end
    end

    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (r_idx < i_head.count))
        else $error("token index beyond its group");

endmodule

`default_nettype wire
